// File: rtl/core/expression_char_lexer_unit_assert.svh
// assertion macros shared by the lexer rtl files
`ifndef EXPRESSION_CHAR_LEXER_UNIT_ASSERT_SVH
`define EXPRESSION_CHAR_LEXER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ECL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecl assertion failed");

// next-cycle implication, disabled during reset
`define ECL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecl assertion failed");

`endif

// File: rtl/core/ecl_pkg.sv
// shared types, constants and character classifiers of the expression lexer
package ecl_pkg;

    // input length limit and the saturation point of the character offset
    localparam logic [31:0] MAX_INPUT_LEN = 32'd65535;
    localparam logic [15:0] OFFSET_CAP =
        (MAX_INPUT_LEN < 32'd65535) ? MAX_INPUT_LEN[15:0] : 16'hFFFF;

    // token kinds
    localparam logic [1:0] KIND_NUM   = 2'd0;
    localparam logic [1:0] KIND_PUNCT = 2'd1;
    localparam logic [1:0] KIND_EOF   = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // token queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QCNT_W-1:0] QUEUE_SPACE_MARK = QCNT_W'(QUEUE_DEPTH - 2);

    // lexer mode, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_NUM  = 4'b0010,
        MODE_HELD = 4'b0100,
        MODE_ERR  = 4'b1000
    } lex_mode_t;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [31:0] number_value;
        logic        value_overflow;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [7:0]  first_char;
        logic [7:0]  second_char;
        logic        final_token;
    } token_t;

    // up to two tokens handed from the lexer core to the queue per word
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } tok_push_t;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, [8'd9:8'd13]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'd48:8'd57]};
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
    endfunction

    function automatic logic is_holdable(input logic [7:0] c);
        return c inside {CH_EQ, CH_BANG, CH_LT, CH_GT};
    endfunction

    // accum * 10 + digit; msb is the carry out of 32 bits
    function automatic logic [32:0] mul10_add(input logic [31:0] a, input logic [3:0] d);
        logic [35:0] s;
        s = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {32'd0, d};
        return {|s[35:32], s[31:0]};
    endfunction

endpackage

// File: rtl/core/ecl_char_if.sv
// character input channel
interface ecl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_marker;

    modport source (output valid, output char_code, output end_marker, input ready);
    modport sink (input valid, input char_code, input end_marker, output ready);
endinterface

// File: rtl/core/ecl_token_if.sv
// token output channel
interface ecl_token_if;
    logic        valid;
    logic        ready;
    logic [1:0]  token_kind;
    logic [31:0] number_value;
    logic        value_overflow;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic        final_token;

    modport source (
        output valid, output token_kind, output number_value, output value_overflow,
        output start_offset, output token_length, output first_char,
        output second_char, output final_token, input ready
    );
    modport sink (
        input valid, input token_kind, input number_value, input value_overflow,
        input start_offset, input token_length, input first_char,
        input second_char, input final_token, output ready
    );
endinterface

// File: rtl/core/ecl_lex_core.sv
// lexer state and per-character token classification
`include "expression_char_lexer_unit_assert.svh"

module ecl_lex_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        char_code,
    input  logic              end_marker,
    output ecl_pkg::tok_push_t push
);

    ecl_pkg::lex_mode_t mode_reg, mode_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] begin_reg, begin_next;
    logic [31:0] accum_reg, accum_next;
    logic        ovf_reg, ovf_next;
    logic [7:0]  held_reg, held_next;

    logic [15:0] off_adv;
    logic        end_in;
    logic [32:0] acc_sum;
    logic [3:0]  digit;
    ecl_pkg::token_t num_tok, held1_tok, held2_tok, eof_tok, punct_tok, err_tok;
    ecl_pkg::token_t pend_tok, new_tok;
    logic        pend_vld, new_vld;
    logic        err_pushed;

    // shared datapath pieces
    assign end_in  = end_marker || (char_code == ecl_pkg::CH_NUL);
    assign off_adv = (offset_reg < ecl_pkg::OFFSET_CAP) ? offset_reg + 16'd1 : offset_reg;
    assign digit   = 4'(char_code - ecl_pkg::CH_ZERO);
    assign acc_sum = ecl_pkg::mul10_add(accum_reg, digit);

    // candidate tokens
    always_comb
    begin
        num_tok = '0;
        num_tok.token_kind     = ecl_pkg::KIND_NUM;
        num_tok.number_value   = accum_reg;
        num_tok.value_overflow = ovf_reg;
        num_tok.start_offset   = begin_reg;
        num_tok.token_length   = offset_reg - begin_reg;

        held1_tok = '0;
        held1_tok.token_kind   = ecl_pkg::KIND_PUNCT;
        held1_tok.start_offset = begin_reg;
        held1_tok.token_length = 16'd1;
        held1_tok.first_char   = held_reg;

        held2_tok = held1_tok;
        held2_tok.token_length = 16'd2;
        held2_tok.second_char  = char_code;

        eof_tok = '0;
        eof_tok.token_kind   = ecl_pkg::KIND_EOF;
        eof_tok.start_offset = offset_reg;
        eof_tok.final_token  = 1'b1;

        punct_tok = '0;
        punct_tok.token_kind   = ecl_pkg::KIND_PUNCT;
        punct_tok.start_offset = offset_reg;
        punct_tok.token_length = 16'd1;
        punct_tok.first_char   = char_code;

        err_tok = punct_tok;
        err_tok.token_kind  = ecl_pkg::KIND_ERR;
        err_tok.final_token = 1'b1;
    end

    // next state and emitted tokens for the accepted word
    always_comb
    begin
        mode_next   = mode_reg;
        offset_next = offset_reg;
        begin_next  = begin_reg;
        accum_next  = accum_reg;
        ovf_next    = ovf_reg;
        held_next   = held_reg;
        pend_vld    = 1'b0;
        pend_tok    = num_tok;
        new_vld     = 1'b0;
        new_tok     = eof_tok;

        if (accept)
        begin
            if (end_in)
            begin
                // flush pending token, close with end token unless in error mode, back to reset state
                if (mode_reg != ecl_pkg::MODE_ERR)
                begin
                    if (mode_reg == ecl_pkg::MODE_NUM)
                    begin
                        pend_vld = 1'b1;
                        pend_tok = num_tok;
                    end
                    else if (mode_reg == ecl_pkg::MODE_HELD)
                    begin
                        pend_vld = 1'b1;
                        pend_tok = held1_tok;
                    end
                    new_vld = 1'b1;
                    new_tok = eof_tok;
                end
                mode_next   = ecl_pkg::MODE_IDLE;
                offset_next = '0;
                begin_next  = '0;
                accum_next  = '0;
                ovf_next    = 1'b0;
                held_next   = '0;
            end
            else if (mode_reg == ecl_pkg::MODE_ERR)
            begin
                offset_next = off_adv;
            end
            else if ((mode_reg == ecl_pkg::MODE_HELD) && (char_code == ecl_pkg::CH_EQ))
            begin
                // two-character operator
                new_vld     = 1'b1;
                new_tok     = held2_tok;
                mode_next   = ecl_pkg::MODE_IDLE;
                offset_next = off_adv;
            end
            else if ((mode_reg == ecl_pkg::MODE_NUM) && ecl_pkg::is_digit(char_code))
            begin
                accum_next  = acc_sum[31:0];
                ovf_next    = ovf_reg | acc_sum[32];
                offset_next = off_adv;
            end
            else
            begin
                // close whatever was pending, then classify this character
                if (mode_reg == ecl_pkg::MODE_NUM)
                begin
                    pend_vld = 1'b1;
                    pend_tok = num_tok;
                end
                else if (mode_reg == ecl_pkg::MODE_HELD)
                begin
                    pend_vld = 1'b1;
                    pend_tok = held1_tok;
                end
                mode_next   = ecl_pkg::MODE_IDLE;
                offset_next = off_adv;
                if (ecl_pkg::is_space(char_code))
                begin
                    mode_next = ecl_pkg::MODE_IDLE;
                end
                else if (ecl_pkg::is_digit(char_code))
                begin
                    mode_next  = ecl_pkg::MODE_NUM;
                    begin_next = offset_reg;
                    accum_next = {28'd0, digit};
                    ovf_next   = 1'b0;
                end
                else if (ecl_pkg::is_holdable(char_code))
                begin
                    mode_next  = ecl_pkg::MODE_HELD;
                    begin_next = offset_reg;
                    held_next  = char_code;
                end
                else if (ecl_pkg::is_punct(char_code))
                begin
                    new_vld = 1'b1;
                    new_tok = punct_tok;
                end
                else
                begin
                    new_vld   = 1'b1;
                    new_tok   = err_tok;
                    mode_next = ecl_pkg::MODE_ERR;
                end
            end
        end
    end

    // pack tokens in emission order
    assign push.count = {1'b0, pend_vld} + {1'b0, new_vld};
    assign push.tok0  = pend_vld ? pend_tok : new_tok;
    assign push.tok1  = new_tok;

    // an error token among the tokens of this word
    assign err_pushed = ((push.count == 2'd1) && (push.tok0.token_kind == ecl_pkg::KIND_ERR)) ||
                        ((push.count == 2'd2) && (push.tok1.token_kind == ecl_pkg::KIND_ERR));

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ecl_pkg::MODE_IDLE;
            offset_reg <= '0;
            begin_reg  <= '0;
            accum_reg  <= '0;
            ovf_reg    <= 1'b0;
            held_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            begin_reg  <= begin_next;
            accum_reg  <= accum_next;
            ovf_reg    <= ovf_next;
            held_reg   <= held_next;
        end
    end

    // a closing token is always the last one of a word
    `ECL_ASSERT_IMPL(a_final_last, clk, rst_n, push.count == 2'd2, !push.tok0.final_token)
    // an error token puts the lexer into error mode
    `ECL_ASSERT_NEXT(a_err_mode, clk, rst_n, err_pushed, mode_reg == ecl_pkg::MODE_ERR)
    // offset saturates
    `ECL_ASSERT_IMPL(a_offset_cap, clk, rst_n, 1'b1, offset_reg <= ecl_pkg::OFFSET_CAP)

endmodule

// File: rtl/core/ecl_tok_queue.sv
// small token queue: up to two writes and one read per cycle
`include "expression_char_lexer_unit_assert.svh"

module ecl_tok_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  ecl_pkg::tok_push_t push,
    input  logic               pop,
    output logic               space_ok,
    output logic               head_valid,
    output ecl_pkg::token_t    head
);

    ecl_pkg::token_t mem_reg [ecl_pkg::QUEUE_DEPTH];
    logic [ecl_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next, wr_ptr_inc;
    logic [ecl_pkg::QCNT_W-1:0] count_reg, count_next;

    // pointer and fill bookkeeping
    assign wr_ptr_inc  = wr_ptr_reg + ecl_pkg::QPTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + ecl_pkg::QPTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + ecl_pkg::QPTR_W'(pop);
    assign count_next  = count_reg + ecl_pkg::QCNT_W'(push.count) - ecl_pkg::QCNT_W'(pop);

    assign space_ok   = (count_reg <= ecl_pkg::QUEUE_SPACE_MARK);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    // token storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // writes only land when two slots are free
    `ECL_ASSERT_IMPL(a_push_room, clk, rst_n, push.count != 2'd0, count_reg <= ecl_pkg::QUEUE_SPACE_MARK)
    // fill level holds when nothing moves
    `ECL_ASSERT_NEXT(a_count_hold, clk, rst_n, (push.count == 2'd0) && !pop, count_reg == $past(count_reg))

endmodule

// File: rtl/core/expression_char_lexer_unit.sv
// top level of the streaming expression lexer
//
//  channel    | dir | words
//  -----------+-----+-------------------------------------------
//  char_in    | in  | one character byte or end marker
//  token_out  | out | one token: kind, value, offsets, operator chars
//
// A character is taken whenever the token queue has two free slots.
// Each character is classified and its tokens written to the queue in the same cycle it is taken.
// Tokens leave one per cycle from the queue head while token_out.ready is high, so a character that
// closes a pending token and makes one of its own puts two tokens on the output.
// rst_n clears the lexer state and empties the queue; nothing else is cleared.
// A stalled token_out fills the queue until fewer than two slots are free, which drops char_in.ready.
module expression_char_lexer_unit (
    input  logic        clk,
    input  logic        rst_n,
    ecl_char_if.sink    char_in,
    ecl_token_if.source token_out
);

    logic               accept;
    logic               pop;
    logic               space_ok;
    logic               head_valid;
    ecl_pkg::tok_push_t push;
    ecl_pkg::token_t    head;

    // handshakes
    assign char_in.ready   = space_ok;
    assign accept          = char_in.valid && space_ok;
    assign token_out.valid = head_valid;
    assign pop             = head_valid && token_out.ready;

    ecl_lex_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .char_code  (char_in.char_code),
        .end_marker (char_in.end_marker),
        .push       (push)
    );

    ecl_tok_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .space_ok   (space_ok),
        .head_valid (head_valid),
        .head       (head)
    );

    // output word fields
    assign token_out.token_kind     = head.token_kind;
    assign token_out.number_value   = head.number_value;
    assign token_out.value_overflow = head.value_overflow;
    assign token_out.start_offset   = head.start_offset;
    assign token_out.token_length   = head.token_length;
    assign token_out.first_char     = head.first_char;
    assign token_out.second_char    = head.second_char;
    assign token_out.final_token    = head.final_token;

endmodule
